[sv/vat_pkg.sv]
package vat_pkg;

  // digits folded before the check character
  localparam int unsigned DIGIT_COUNT = 8;
  localparam int unsigned DIGITS_W    = $clog2(DIGIT_COUNT + 1);

  // identifier length window and counter ceiling
  localparam logic [3:0] MIN_LEN   = 4'd9;
  localparam logic [3:0] MAX_LEN   = 4'd14;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // product seed and ascii codes
  localparam logic [3:0] PROD_INIT = 4'd10;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [1:0] ASCII_HI  = 2'b11;

  // depth of the queues between the parts
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       malformed;
    logic [5:0] expected_check;
    logic       mismatch;
  } result_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       body;
    logic       last;
    logic       len_ok;
  } token_t;

  // ascii digit test
  function automatic logic is_digit(input logic [7:0] c);
    return (c[7:4] == 4'h3) && (c[3:0] < 4'd10);
  endfunction

  // one mod 11,10 step: ((p + d) mod 10, zero as ten) doubled mod 11
  function automatic logic [3:0] fold(input logic [3:0] p, input logic [3:0] d);
    logic [4:0] sum;
    logic [4:0] s;
    logic [4:0] dbl;
    sum = 5'(p) + 5'(d);
    s   = (sum >= 5'd10) ? sum - 5'd10 : sum;
    if (s == 5'd0) begin
      s = 5'd10;
    end
    dbl = {s[3:0], 1'b0};
    return (dbl >= 5'd11) ? 4'(dbl - 5'd11) : dbl[3:0];
  endfunction

  // check digit (11 - p) mod 10 for p in 1..10
  function automatic logic [3:0] check_digit(input logic [3:0] p);
    return (p == 4'd1) ? 4'd0 : 4'(5'd11 - 5'(p));
  endfunction

endpackage

[sv/vat_front.sv]
module vat_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  vat_pkg::item_t item,
  output logic           tok_push,
  input  logic           tok_full,
  output vat_pkg::token_t tok
);

  typedef enum logic [1:0] {
    PH_START,
    PH_AFTER_D,
    PH_BODY
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] byte_count, byte_count_next;
  logic       body;
  logic       take;

  assign full     = tok_full;
  assign take     = push && !tok_full;
  assign tok_push = take;

  // saturating length count
  assign byte_count_next = (byte_count < vat_pkg::COUNT_MAX) ? byte_count + 4'd1 : byte_count;

  // prefix handling: optional D, then optional E
  always_comb begin
    phase_next = phase;
    body       = 1'b1;
    case (phase)
      PH_START: begin
        phase_next = (item.ch == vat_pkg::CH_D) ? PH_AFTER_D : PH_BODY;
        body       = (item.ch != vat_pkg::CH_D) && (item.ch != vat_pkg::CH_E);
      end
      PH_AFTER_D: begin
        phase_next = PH_BODY;
        body       = (item.ch != vat_pkg::CH_E);
      end
      PH_BODY: begin
        phase_next = PH_BODY;
        body       = 1'b1;
      end
      default: begin
        phase_next = PH_BODY;
        body       = 1'b1;
      end
    endcase
  end

  // classified byte
  always_comb begin
    tok.ch     = item.ch;
    tok.body   = body;
    tok.last   = item.last;
    tok.len_ok = (byte_count_next >= vat_pkg::MIN_LEN) && (byte_count_next <= vat_pkg::MAX_LEN);
  end

  // per identifier state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      byte_count <= '0;
    end else if (take) begin
      if (item.last) begin
        phase      <= PH_START;
        byte_count <= '0;
      end else begin
        phase      <= phase_next;
        byte_count <= byte_count_next;
      end
    end
  end

endmodule

[sv/vat_tok_q.sv]
module vat_tok_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  vat_pkg::token_t wr_tok,
  input  logic            pop,
  output logic            empty,
  output vat_pkg::token_t rd_tok
);

  vat_pkg::token_t                  mem [vat_pkg::QDEPTH];
  logic [vat_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [vat_pkg::QCNT_W-1:0]       count;
  logic                             do_push, do_pop;

  assign full    = (count == vat_pkg::QCNT_W'(vat_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_tok  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/vat_back.sv]
module vat_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_empty,
  output logic             tok_pop,
  input  vat_pkg::token_t  tok,
  input  logic             pop,
  output logic             empty,
  output vat_pkg::result_t result
);

  logic [vat_pkg::DIGITS_W-1:0] digits_taken, digits_next;
  logic [3:0]                   product, product_next;
  logic                         check_seen, check_seen_next;
  logic [7:0]                   received_check, received_next;
  logic                         bad_flag, bad_next;
  vat_pkg::result_t             res_new;
  logic [3:0]                   chk;

  vat_pkg::result_t             oq [vat_pkg::QDEPTH];
  logic [vat_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [vat_pkg::QCNT_W-1:0]   count;
  logic                         oq_full;
  logic                         step;
  logic                         emit;
  logic                         do_pop;

  assign oq_full = (count == vat_pkg::QCNT_W'(vat_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign step    = !tok_empty && !oq_full;
  assign tok_pop = step;
  assign emit    = step && tok.last;
  assign do_pop  = pop && !empty;
  assign result  = oq[rd_ptr];

  // body byte: digits, spaces, check character, trailing bytes
  always_comb begin
    digits_next     = digits_taken;
    product_next    = product;
    check_seen_next = check_seen;
    received_next   = received_check;
    bad_next        = bad_flag;
    if (tok.body) begin
      if (check_seen) begin
        bad_next = 1'b1;
      end else if (digits_taken >= vat_pkg::DIGITS_W'(vat_pkg::DIGIT_COUNT)) begin
        received_next   = tok.ch;
        check_seen_next = 1'b1;
      end else if (tok.ch == vat_pkg::CH_SPACE) begin
        bad_next = bad_flag;
      end else if (!vat_pkg::is_digit(tok.ch)) begin
        bad_next = 1'b1;
      end else begin
        product_next = vat_pkg::fold(product, tok.ch[3:0]);
        digits_next  = digits_taken + 1'b1;
      end
    end
  end

  // result of the identifier on its last byte
  always_comb begin
    chk = vat_pkg::check_digit(product_next);
    if (bad_next || !tok.len_ok) begin
      res_new.malformed      = 1'b1;
      res_new.expected_check = '0;
      res_new.mismatch       = 1'b0;
    end else begin
      res_new.malformed      = 1'b0;
      res_new.expected_check = {vat_pkg::ASCII_HI, chk};
      res_new.mismatch       = !check_seen_next ||
                               (received_next != {2'b00, vat_pkg::ASCII_HI, chk});
    end
  end

  // check state, cleared after each identifier
  always_ff @(posedge clk) begin
    if (rst) begin
      digits_taken   <= '0;
      product        <= vat_pkg::PROD_INIT;
      check_seen     <= 1'b0;
      received_check <= '0;
      bad_flag       <= 1'b0;
    end else if (step) begin
      if (tok.last) begin
        digits_taken   <= '0;
        product        <= vat_pkg::PROD_INIT;
        check_seen     <= 1'b0;
        received_check <= '0;
        bad_flag       <= 1'b0;
      end else begin
        digits_taken   <= digits_next;
        product        <= product_next;
        check_seen     <= check_seen_next;
        received_check <= received_next;
        bad_flag       <= bad_next;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (emit) begin
      oq[wr_ptr] <= res_new;
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (emit) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (emit && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !emit) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/vat_id_check_mod11_10_stream_top.sv]
// VAT identifier check, ISO 7064 MOD 11,10, one ASCII byte per request.
// Input channel: drive item (ch, last) with push; the byte is taken at a
// clock edge where push is high and full is low. last marks the final byte.
// Result channel: while empty is low, result holds the oldest result
// (malformed, expected_check, mismatch); it is taken at an edge where pop is
// high. One result comes per identifier, on its last byte; other bytes give
// none.
// Throughput: one byte per cycle while full is low. The front classifies each byte (length,
// optional D and E prefix) and hands it through a two-entry queue to the
// back, which folds each digit into a registered product and writes the
// result into a two-entry result queue.
// A last byte is first stored in the token queue; its result is written into
// the result queue when the back takes that byte from the token queue.
// Stall: when pop stays low the result queue fills, the back stops, the
// token queue fills and full rises; nothing is dropped.
// Reset (rst, synchronous): both queues empty, all check state cleared, full
// low and empty high on the next cycle.
module vat_id_check_mod11_10_stream_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  vat_pkg::item_t   item,
  input  logic             pop,
  output logic             empty,
  output vat_pkg::result_t result
);

  logic            f_push, f_full;
  logic            b_pop, b_empty;
  vat_pkg::token_t f_tok, b_tok;

  // byte classification
  vat_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .tok_push (f_push),
    .tok_full (f_full),
    .tok      (f_tok)
  );

  // decoupling queue
  vat_tok_q u_tok_q (
    .clk    (clk),
    .rst    (rst),
    .push   (f_push),
    .full   (f_full),
    .wr_tok (f_tok),
    .pop    (b_pop),
    .empty  (b_empty),
    .rd_tok (b_tok)
  );

  // check digit fold and result queue
  vat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_empty (b_empty),
    .tok_pop   (b_pop),
    .tok       (b_tok),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  // malformed results carry no digit and no mismatch
  a_malformed_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.malformed) |-> (result.expected_check == 6'd0 && !result.mismatch))
    else $error("malformed result carries check data");

  // well formed results carry an ascii digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.malformed) |->
      (result.expected_check[5:4] == vat_pkg::ASCII_HI && result.expected_check[3:0] < 4'd10))
    else $error("expected check is not an ascii digit");

  // both channels come out of reset idle
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> (!full && empty))
    else $error("queues not empty after reset");

  // no result appears without a byte reaching the back
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(!empty) && !$past(rst)) |-> $past(b_pop && b_tok.last))
    else $error("result appeared without a last byte");

endmodule

[dv/tb_vat_id_check_mod11_10_stream_top.sv]
module tb_vat_id_check_mod11_10_stream_top;

  typedef enum logic [1:0] {PH_START, PH_AFTER_D, PH_BODY} id_phase_t;
  typedef enum int {CHK_GOOD, CHK_WRONG, CHK_GIVEN, CHK_NONE} chk_mode_t;
  typedef enum int {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic             clk  = 1'b0;
  logic             rst  = 1'b1;
  logic             push = 1'b0;
  logic             full;
  vat_pkg::item_t   item = '0;
  logic             pop  = 1'b0;
  logic             empty;
  vat_pkg::result_t result;

  // bytes waiting to be sent and verdicts waiting to come back
  vat_pkg::item_t   pending_bytes[$];
  vat_pkg::result_t expected_verdicts[$];
  int               error_count = 0;

  // predicted identifier state
  logic [3:0] id_len;
  id_phase_t  id_phase;
  logic [3:0] id_digits;
  logic [3:0] id_prod;
  logic       id_check_seen;
  logic [7:0] id_check_ch;
  logic       id_bad;

  // sender and receiver pacing
  int               burst_left = 1;
  int               gap_left = 0;
  int               hold_left = 0;
  int               mode_left = 0;
  rx_mode_t         rx_mode = RX_FREE;
  vat_pkg::result_t step_verdict;

  vat_id_check_mod11_10_stream_top uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  always #5 clk = ~clk;

  // one mod 11,10 step on the running product
  function automatic logic [3:0] mod_step(input logic [3:0] p, input logic [3:0] d);
    int s;
    s = (int'(p) + int'(d)) % 10;
    if (s == 0) begin
      s = 10;
    end
    return 4'((2 * s) % 11);
  endfunction

  function automatic void clear_id_state();
    id_len        = '0;
    id_phase      = PH_START;
    id_digits     = '0;
    id_prod       = 4'd10;
    id_check_seen = 1'b0;
    id_check_ch   = '0;
    id_bad        = 1'b0;
  endfunction

  // advance the predicted state by one byte; returns 1 when a verdict is due
  function automatic bit predict_verdict(input vat_pkg::item_t it,
                                         output vat_pkg::result_t verdict);
    logic       to_body;
    logic [7:0] d;
    logic [3:0] chk;
    verdict = '0;
    to_body = 1'b0;
    if (id_len < vat_pkg::COUNT_MAX) begin
      id_len = id_len + 4'd1;
    end
    // optional D, then optional E
    case (id_phase)
      PH_START: begin
        if (it.ch == vat_pkg::CH_D) begin
          id_phase = PH_AFTER_D;
        end else begin
          id_phase = PH_BODY;
          to_body  = (it.ch != vat_pkg::CH_E);
        end
      end
      PH_AFTER_D: begin
        id_phase = PH_BODY;
        to_body  = (it.ch != vat_pkg::CH_E);
      end
      default: to_body = 1'b1;
    endcase
    // digits, then the check byte, then anything is an error
    if (to_body) begin
      d = it.ch ^ 8'h30;
      if (id_check_seen) begin
        id_bad = 1'b1;
      end else if (id_digits >= vat_pkg::DIGIT_COUNT) begin
        id_check_ch   = it.ch;
        id_check_seen = 1'b1;
      end else if (it.ch != vat_pkg::CH_SPACE) begin
        if (d >= 8'd10) begin
          id_bad = 1'b1;
        end else begin
          id_prod   = mod_step(id_prod, d[3:0]);
          id_digits = id_digits + 4'd1;
        end
      end
    end
    if (!it.last) begin
      return 1'b0;
    end
    chk = 4'((11 - int'(id_prod)) % 10);
    if (id_bad || id_len < vat_pkg::MIN_LEN || id_len > vat_pkg::MAX_LEN) begin
      verdict.malformed = 1'b1;
    end else begin
      verdict.expected_check = {2'b11, chk};
      verdict.mismatch       = !id_check_seen || (id_check_ch != {4'h3, chk});
    end
    clear_id_state();
    return 1'b1;
  endfunction

  // queue one identifier: prefix, digits with spaces, check byte, trailing bytes
  task automatic add_id(input int pre, input int ndig, input int nsp, input chk_mode_t chk_mode,
                        input logic [7:0] chk_byte, input int bad_at, input int ntrail);
    logic [7:0] seq[$];
    logic [3:0] p;
    logic [3:0] dg;
    logic [7:0] b;
    int         good;
    int         sp_left;
    p       = 4'd10;
    sp_left = nsp;
    if (pre == 1 || pre == 3) begin
      seq.push_back(vat_pkg::CH_D);
    end
    if (pre >= 2) begin
      seq.push_back(vat_pkg::CH_E);
    end
    for (int i = 0; i < ndig; i++) begin
      // spaces only ahead of a digit, never where the check byte goes
      while (sp_left > 0 && (i == ndig - 1 || $urandom_range(0, 1) == 1)) begin
        seq.push_back(vat_pkg::CH_SPACE);
        sp_left--;
      end
      if (i == bad_at) begin
        do begin
          b = 8'($urandom_range(0, 255));
        end while ((b ^ 8'h30) < 8'd10 || b == vat_pkg::CH_SPACE);
        seq.push_back(b);
      end else begin
        dg = 4'($urandom_range(0, 9));
        p  = mod_step(p, dg);
        seq.push_back({4'h3, dg});
      end
    end
    repeat (sp_left) seq.push_back(vat_pkg::CH_SPACE);
    good = (11 - int'(p)) % 10;
    case (chk_mode)
      CHK_GOOD:  seq.push_back(8'(8'h30 + good));
      CHK_WRONG: seq.push_back(8'(8'h30 + (good + $urandom_range(1, 9)) % 10));
      CHK_GIVEN: seq.push_back(chk_byte);
      default:   ;
    endcase
    repeat (ntrail) seq.push_back(8'($urandom_range(0, 255)));
    if (seq.size() == 0) begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[k]) begin
      pending_bytes.push_back(vat_pkg::item_t'{ch: seq[k], last: (k == seq.size() - 1)});
    end
  endtask

  // sender: bursts of requests with random gaps, starting only after an accepted byte
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (predict_verdict(pending_bytes.pop_front(), step_verdict)) begin
          expected_verdicts.push_back(step_verdict);
        end
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        push <= 1'b1;
        item <= pending_bytes[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: check each popped verdict, stall in changing modes
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with nothing expected: %p", result);
          error_count++;
        end else begin
          step_verdict = expected_verdicts.pop_front();
          if (result.malformed !== step_verdict.malformed) begin
            $error("malformed: expected %0d, got %0d", step_verdict.malformed, result.malformed);
            error_count++;
          end
          if (result.expected_check !== step_verdict.expected_check) begin
            $error("expected_check: expected %0h, got %0h",
                   step_verdict.expected_check, result.expected_check);
            error_count++;
          end
          if (result.mismatch !== step_verdict.mismatch) begin
            $error("mismatch: expected %0d, got %0d", step_verdict.mismatch, result.mismatch);
            error_count++;
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_left == 0) begin
        case (rx_mode)
          RX_CHOPPY: if ($urandom_range(0, 2) == 0) hold_left = $urandom_range(1, 3);
          RX_SLOW:   if ($urandom_range(0, 9) == 0) hold_left = $urandom_range(4, 25);
          default:   ;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int        kind;
    int        sel;
    int        pre;
    int        prelen;
    int        n_target;
    chk_mode_t cm;
    clear_id_state();

    // directed: E as first byte, byte extremes, D without E and a space as check byte
    add_id(2, vat_pkg::DIGIT_COUNT, 0, CHK_GOOD, 8'h00, -1, 0);
    add_id(0, 0, 0, CHK_GIVEN, 8'hFF, -1, 0);
    add_id(0, 0, 0, CHK_GIVEN, 8'h00, -1, 0);
    add_id(1, vat_pkg::DIGIT_COUNT, 1, CHK_GIVEN, vat_pkg::CH_SPACE, -1, 0);

    // random: mostly well formed, some broken, some noise
    n_target = pending_bytes.size() + 1550;
    while (pending_bytes.size() < n_target) begin
      kind   = $urandom_range(0, 99);
      pre    = $urandom_range(0, 3);
      prelen = (pre == 3) ? 2 : ((pre == 0) ? 0 : 1);
      if (kind < 70) begin
        sel = $urandom_range(0, 99);
        cm  = (sel < 70) ? CHK_GOOD : (sel < 85) ? CHK_WRONG : (sel < 95) ? CHK_GIVEN : CHK_NONE;
        add_id(pre, vat_pkg::DIGIT_COUNT, $urandom_range(0, 5 - prelen), cm,
               8'($urandom_range(0, 255)), -1, 0);
      end else if (kind < 85) begin
        case ($urandom_range(0, 3))
          // bad character among the digits
          0: add_id(pre, vat_pkg::DIGIT_COUNT, $urandom_range(0, 2), CHK_GOOD, 8'h00,
                    $urandom_range(0, vat_pkg::DIGIT_COUNT - 1), 0);
          // bytes after the check byte
          1: add_id(pre, vat_pkg::DIGIT_COUNT, 0, CHK_GOOD, 8'h00, -1, $urandom_range(1, 3));
          // too few digits
          2: add_id(pre, $urandom_range(0, vat_pkg::DIGIT_COUNT - 1), $urandom_range(0, 3),
                    CHK_GOOD, 8'h00, -1, 0);
          // long identifiers, some past the length limit, up to counter saturation
          default: add_id(pre, vat_pkg::DIGIT_COUNT, $urandom_range(4, 10), CHK_GOOD, 8'h00,
                          -1, 0);
        endcase
      end else begin
        add_id(0, 0, 0, CHK_NONE, 8'h00, -1, $urandom_range(1, 20));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[vat_id_check_mod11_10_stream_top.f]
sv/vat_pkg.sv
sv/vat_front.sv
sv/vat_tok_q.sv
sv/vat_back.sv
sv/vat_id_check_mod11_10_stream_top.sv
dv/tb_vat_id_check_mod11_10_stream_top.sv
